/* rtl/mvot_pkg.sv */
// Package for the multi-valve one-shot timer: beat structs, opcodes, sequencer states
// and the fixed field widths. No dependencies.
package mvot_pkg;

  // Field widths fixed by the beat formats
  localparam int DUR_W   = 15;            // duration field
  localparam int ELP_W   = DUR_W + 1;     // elapsed counter, saturating
  localparam int PROG_W  = 7;             // progress percentage
  localparam int NUM_W   = ELP_W + PROG_W; // elapsed * 100 and remainder
  localparam int MASK_W  = 4;             // valve mask fields
  localparam int MAX_CH  = 4;             // channels carried by a start beat
  localparam int PCT     = 100;
  localparam int QBIT_W  = $clog2(PROG_W);

  // Opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [DUR_W-1:0] duration_a;
    logic [DUR_W-1:0] duration_b;
    logic [DUR_W-1:0] duration_c;
    logic [DUR_W-1:0] duration_d;
  } mvot_in_t;

  typedef struct packed {
    logic [MASK_W-1:0] open_mask;
    logic [MASK_W-1:0] closed_now;
    logic              busy_res;
    logic [PROG_W-1:0] progress;
  } mvot_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } mvot_state_t;

endpackage

/* rtl/mvot_cmp_sub.sv */
// Shared compare/subtract unit of the valve timer: unsigned a >= b and a - b.
// Depends on nothing; width is set by the instantiating module.
module mvot_cmp_sub #(
  parameter int W = 23
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge,
  output logic [W-1:0] diff
);

  logic [W:0] sub;

  // One subtractor; the borrow gives the compare
  assign sub  = {1'b0, a} - {1'b0, b};
  assign ge   = ~sub[W];
  assign diff = sub[W-1:0];

endmodule

/* rtl/multi_valve_one_shot_timer_core.sv */
// Top level of the multi-valve one-shot timer: sequencer, state and result register.
// Depends on mvot_pkg and mvot_cmp_sub.
//
//   channel  dir  beat type   handshake
//   in_      in   mvot_in_t   in_valid / in_ready
//   out_     out  mvot_out_t  out_valid / out_ready
//
// One beat at a time through a single compare/subtract unit:
//   tick while idle: IDLE then FIN; start: IDLE, a scan of the channels, then FIN;
//   tick while busy: the same scan, plus MUL and the 7-step DIV when a valve is still running.
// The channel scan and the 7-step restoring division for progress set these sequences.
// Reset (rst_n low, synchronous) closes all valves and clears the timer.
// The result sits in an output register; a stalled out_ready holds the
// sequencer in its final step, and in_ready stays low until it is free.
module multi_valve_one_shot_timer_core #(
  parameter int CHANNELS = mvot_pkg::MAX_CH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mvot_pkg::mvot_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mvot_pkg::mvot_out_t out_data
);

  import mvot_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  mvot_state_t state_r, state_nxt;

  logic                   op_r;
  logic [DUR_W-1:0]       dur_r [CHANNELS];
  logic [DUR_W-1:0]       longest_r;
  logic [ELP_W-1:0]       elapsed_r;
  logic [CHANNELS-1:0]    open_r;
  logic [CHANNELS-1:0]    closed_r;
  logic                   running_r;
  logic                   active_r;
  logic [CH_W-1:0]        ch_r;
  logic [NUM_W-1:0]       rem_r;
  logic [PROG_W-1:0]      quo_r;
  logic [QBIT_W-1:0]      qbit_r;
  logic                   out_valid_r;
  mvot_out_t              out_data_r;

  logic                   in_fire;
  logic                   ch_last;
  logic                   out_free;
  logic [DUR_W-1:0]       dur_in [MAX_CH];
  logic                   start_any;
  logic [DUR_W-1:0]       dur_cur;
  logic                   chan_active;
  logic [NUM_W-1:0]       alu_a, alu_b, alu_diff;
  logic                   alu_ge;
  logic [NUM_W-1:0]       elp_ext;
  logic [MASK_W-1:0]      open_ext, closed_ext;

  assign in_fire  = in_valid && in_ready;
  assign ch_last  = (ch_r == CH_W'(CHANNELS - 1));
  assign out_free = !out_valid_r || out_ready;
  assign dur_cur  = dur_r[ch_r];
  assign elp_ext  = NUM_W'(elapsed_r);

  assign dur_in[0] = in_data.duration_a;
  assign dur_in[1] = in_data.duration_b;
  assign dur_in[2] = in_data.duration_c;
  assign dur_in[3] = in_data.duration_d;

  // Any channel given a nonzero duration on a start beat
  always_comb begin
    start_any = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (dur_in[i] != '0) start_any = 1'b1;
    end
  end

  // Operand select for the shared unit
  always_comb begin
    alu_a = rem_r;
    alu_b = NUM_W'(longest_r) << qbit_r;
    if (state_r == ST_SCAN) begin
      if (op_r == OP_START) begin
        alu_a = NUM_W'(longest_r);
        alu_b = NUM_W'(dur_cur);
      end else begin
        alu_a = NUM_W'(dur_cur);
        alu_b = elp_ext;
      end
    end
  end

  mvot_cmp_sub #(.W(NUM_W)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .ge   (alu_ge),
    .diff (alu_diff)
  );

  // Channel still counting: nonzero duration not yet passed
  assign chan_active = (dur_cur != '0) && alu_ge;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == OP_START || running_r) state_nxt = ST_SCAN;
          else state_nxt = ST_FIN;
        end
      end
      ST_SCAN: begin
        if (ch_last) begin
          if (op_r == OP_TICK && (active_r || chan_active)) state_nxt = ST_MUL;
          else state_nxt = ST_FIN;
        end
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (qbit_r == '0) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  // Zero-extend channel masks to the beat width
  always_comb begin
    open_ext   = '0;
    closed_ext = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      open_ext[i]   = open_r[i];
      closed_ext[i] = closed_r[i];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) dur_r[i] <= '0;
      longest_r <= '0;
      elapsed_r <= '0;
      open_r    <= '0;
      running_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_data.opcode == OP_START) begin
              elapsed_r <= '0;
              longest_r <= '0;
              running_r <= start_any;
              for (int i = 0; i < CHANNELS; i++) begin
                dur_r[i]  <= dur_in[i];
                open_r[i] <= (dur_in[i] != '0);
              end
            end else if (running_r && elapsed_r != '1) begin
              elapsed_r <= elapsed_r + 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (op_r == OP_START) begin
            if (!alu_ge) longest_r <= dur_cur;
          end else begin
            if (dur_cur != '0 && !alu_ge) open_r[ch_r] <= 1'b0;
            if (ch_last) running_r <= active_r || chan_active;
          end
        end
        default: ;
      endcase
    end
  end

  // Per-beat working registers and result
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        op_r     <= in_data.opcode;
        ch_r     <= '0;
        active_r <= 1'b0;
        closed_r <= '0;
        quo_r    <= '0;
      end
      ST_SCAN: begin
        ch_r <= ch_r + 1'b1;
        if (op_r == OP_TICK) begin
          if (chan_active) active_r <= 1'b1;
          if (dur_cur != '0 && !alu_ge && open_r[ch_r]) closed_r[ch_r] <= 1'b1;
        end
      end
      ST_MUL: begin
        // elapsed * 100 = e*64 + e*32 + e*4
        rem_r  <= (elp_ext << 6) + (elp_ext << 5) + (elp_ext << 2);
        qbit_r <= QBIT_W'(PROG_W - 1);
      end
      ST_DIV: begin
        if (alu_ge) begin
          rem_r         <= alu_diff;
          quo_r[qbit_r] <= 1'b1;
        end
        qbit_r <= qbit_r - 1'b1;
      end
      ST_FIN: begin
        if (out_free) begin
          out_data_r.open_mask  <= open_ext;
          out_data_r.closed_now <= closed_ext;
          out_data_r.busy_res   <= running_r;
          out_data_r.progress   <= running_r ? quo_r : '0;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/mvot_checker.sv */
// Port-level checks for the multi-valve one-shot timer, bound to the top level.
// Depends on mvot_pkg and multi_valve_one_shot_timer_core.
module mvot_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input mvot_pkg::mvot_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input mvot_pkg::mvot_out_t out_data
);

  import mvot_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // One beat at a time: no accept in the cycle after an accept
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous beat in work");

  // A valve reported closed is no longer open
  a_closed_not_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.open_mask & out_data.closed_now) == '0)
    else $error("valve closed and open in one result");

  // Idle results carry zero progress, busy ones stay within 100
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.busy_res || out_data.progress == '0) &&
                  (out_data.progress <= PROG_W'(PCT)))
    else $error("progress out of range");

endmodule

bind multi_valve_one_shot_timer_core mvot_checker u_mvot_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* bench/multi_valve_one_shot_timer_core_test.sv */
// Self-checking bench for multi_valve_one_shot_timer_core: directed and random valve runs,
// checked beat by beat against an in-bench valve timer model. Depends on mvot_pkg and the RTL.
module multi_valve_one_shot_timer_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mvot_pkg::*;

  localparam int          CHANNELS    = MAX_CH;
  localparam int unsigned ITEMS       = 1150;
  localparam int unsigned STALL_LIMIT = 1000;   // cycles with no beat on either side
  localparam int unsigned DRAIN_WAIT  = 40;     // beyond the worst-case beat latency
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned DUR_MAX     = (1 << DUR_W) - 1;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  mvot_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mvot_out_t out_data;

  // Valve timer model state
  logic [DUR_W-1:0]  valve_dur [MAX_CH];
  logic [DUR_W-1:0]  longest_dur  = '0;
  logic [ELP_W-1:0]  ticks_elapsed = '0;
  logic [MASK_W-1:0] valves_open  = '0;
  logic              dispensing   = 1'b0;

  mvot_out_t   expected_results[$];
  int unsigned mismatches    = 0;
  int unsigned beats_sent    = 0;
  int unsigned starts_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned valves_closed = 0;
  int unsigned long_holds    = 0;
  int unsigned sink_hold_req = 0;
  bit          send_back_to_back = 1'b0;
  bit          sink_always_ready = 1'b0;

  always #4 clk = ~clk;

  multi_valve_one_shot_timer_core #(
    .CHANNELS(CHANNELS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    for (int i = 0; i < MAX_CH; i++) valve_dur[i] = '0;
  end

  // Advance the valve timer by one beat and return the status it should report
  function automatic mvot_out_t apply_valve_beat(input mvot_in_t beat);
    logic [DUR_W-1:0]  req [MAX_CH];
    logic [MASK_W-1:0] shut;
    int unsigned       still;
    logic [31:0]       pct;
    mvot_out_t         status;
    req[0] = beat.duration_a;
    req[1] = beat.duration_b;
    req[2] = beat.duration_c;
    req[3] = beat.duration_d;
    shut   = '0;
    still  = 0;
    if (beat.opcode == OP_START) begin
      ticks_elapsed = '0;
      longest_dur   = '0;
      valves_open   = '0;
      dispensing    = 1'b0;
      for (int i = 0; i < MAX_CH; i++) begin
        valve_dur[i] = (i < CHANNELS) ? req[i] : '0;
        if (valve_dur[i] > longest_dur) longest_dur = valve_dur[i];
        if (valve_dur[i] != '0) begin
          valves_open[i] = 1'b1;
          dispensing     = 1'b1;
        end
      end
    end else if (dispensing) begin
      if (ticks_elapsed != '1) ticks_elapsed = ticks_elapsed + 1'b1;
      for (int i = 0; i < MAX_CH; i++) begin
        if (valve_dur[i] != '0) begin
          if (ticks_elapsed > valve_dur[i]) begin
            if (valves_open[i]) shut[i] = 1'b1;
            valves_open[i] = 1'b0;
          end else begin
            still++;
          end
        end
      end
      if (still == 0) dispensing = 1'b0;
    end
    // progress is taken after the tick, truncated and clamped
    pct = '0;
    if (dispensing && longest_dur != '0) begin
      pct = (32'(ticks_elapsed) * PCT) / 32'(longest_dur);
      if (pct > PCT) pct = PCT;
    end
    status.open_mask  = valves_open;
    status.closed_now = shut;
    status.busy_res   = dispensing;
    status.progress   = PROG_W'(pct);
    return status;
  endfunction

  function automatic mvot_in_t make_start(input int unsigned a, input int unsigned b,
                                          input int unsigned c, input int unsigned d);
    mvot_in_t beat;
    beat.opcode     = OP_START;
    beat.duration_a = DUR_W'(a);
    beat.duration_b = DUR_W'(b);
    beat.duration_c = DUR_W'(c);
    beat.duration_d = DUR_W'(d);
    return beat;
  endfunction

  // Tick beats carry junk in the duration fields; the block must ignore it
  function automatic mvot_in_t make_tick();
    mvot_in_t beat;
    beat = make_start($urandom_range(0, DUR_MAX), $urandom_range(0, DUR_MAX),
                      $urandom_range(0, DUR_MAX), $urandom_range(0, DUR_MAX));
    beat.opcode = OP_TICK;
    return beat;
  endfunction

  function automatic mvot_in_t make_noise();
    mvot_in_t beat;
    beat = make_tick();
    beat.opcode = $urandom_range(0, 1) ? OP_START : OP_TICK;
    return beat;
  endfunction

  // A channel is left closed about a quarter of the time
  function automatic int unsigned pick_duration(input int unsigned max_dur);
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(1, max_dur);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // Send one beat after a random gap; the model advances when it is taken
  task automatic send_beat(input mvot_in_t beat);
    int unsigned gap;
    gap = send_back_to_back ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(apply_valve_beat(beat));
    beats_sent++;
    if (beat.opcode == OP_START) starts_sent++;
  endtask

  task automatic check_result(input mvot_out_t got);
    mvot_out_t want;
    if (expected_results.size() == 0) begin
      flag_mismatch($sformatf("result %h with nothing outstanding", got));
      return;
    end
    want = expected_results.pop_front();
    if (got.open_mask !== want.open_mask)
      flag_mismatch($sformatf("open_mask %h, want %h", got.open_mask, want.open_mask));
    if (got.closed_now !== want.closed_now)
      flag_mismatch($sformatf("closed_now %h, want %h", got.closed_now, want.closed_now));
    if (got.busy_res !== want.busy_res)
      flag_mismatch($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
    if (got.progress !== want.progress)
      flag_mismatch($sformatf("progress %0d, want %0d", got.progress, want.progress));
    valves_closed += $countones(want.closed_now);
    results_seen++;
  endtask

  // One dispense: start, ticks until every valve shut (or cut short), a few idle ticks
  task automatic run_dispense(input int unsigned max_dur, input int unsigned tick_cap);
    int unsigned n;
    n = 0;
    send_beat(make_start(pick_duration(max_dur), pick_duration(max_dur),
                         pick_duration(max_dur), pick_duration(max_dur)));
    while (dispensing && n < tick_cap) begin
      send_beat(make_tick());
      n++;
      if ($urandom_range(0, 59) == 0) break;   // next start lands mid-run
    end
    repeat ($urandom_range(0, 2)) send_beat(make_tick());
  endtask

  task automatic test_idle_ticks();
    send_beat(make_tick());
    send_beat(make_start(0, 0, 0, 0));
    send_beat(make_tick());
  endtask

  task automatic test_field_extremes();
    send_beat(make_start(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX));
    send_beat(make_tick());
    send_beat(make_start('h5555, 'h2AAA, 'h5555, 'h2AAA));
    send_beat(make_tick());
  endtask

  task automatic test_staggered_close();
    send_beat(make_start(1, 2, 3, 4));
    repeat (5) send_beat(make_tick());
  endtask

  task automatic test_restart_while_busy();
    send_beat(make_start(3, 0, 5, 2));
    send_beat(make_tick());
    // a, c and d were open; the restart shuts them without reporting
    send_beat(make_start(0, 2, 0, 0));
    repeat (3) send_beat(make_tick());
  endtask

  task automatic test_back_pressure();
    sink_hold_req     = LONG_HOLD;
    send_back_to_back = 1'b1;
    run_dispense(6, 1000);
    run_dispense(6, 1000);
    send_back_to_back = 1'b0;
  endtask

  task automatic test_no_idle_stretch();
    send_back_to_back = 1'b1;
    sink_always_ready = 1'b1;
    repeat (4) run_dispense(20, 1000);
    send_back_to_back = 1'b0;
    sink_always_ready = 1'b0;
  endtask

  task automatic test_random_mix();
    int unsigned pick;
    while (beats_sent < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      run_dispense($urandom_range(1, 40), 1000);
      else if (pick < 80) run_dispense($urandom_range(41, 150), 1000);
      else if (pick < 90) run_dispense(DUR_MAX, $urandom_range(0, 4));
      else                repeat ($urandom_range(1, 4)) send_beat(make_noise());
    end
  endtask

  // Result side: random stalls, one long hold on request
  initial begin : result_sink
    int unsigned hold;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (sink_hold_req != 0) begin
        hold          = sink_hold_req;
        sink_hold_req = 0;
        long_holds++;
      end else begin
        hold = sink_always_ready ? 0 : $urandom_range(0, 4);
      end
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result(out_data);
    end
  end

  // Watchdog: too long without a beat on either channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", quiet);
        $display("multi_valve_one_shot_timer_core_test NOT OK");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_field_extremes();
    test_staggered_close();
    test_restart_while_busy();
    test_back_pressure();
    test_no_idle_stretch();
    test_random_mix();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Ran %0d beats (%0d starts) and checked %0d results, %0d valve closures seen",
             beats_sent, starts_sent, results_seen, valves_closed);
    $display("Output held off for long stretches %0d time(s); %0d mismatches",
             long_holds, mismatches);
    if (mismatches == 0) begin
      $display("multi_valve_one_shot_timer_core_test OK");
    end else begin
      $display("multi_valve_one_shot_timer_core_test NOT OK");
    end
    $finish;
  end

endmodule
